// ----- sv/bar_coincidence_hitmap_unit_assert.svh -----
// Assertion macros for the bar coincidence hit map
`ifndef BAR_COINCIDENCE_HITMAP_UNIT_ASSERT_SVH
`define BAR_COINCIDENCE_HITMAP_UNIT_ASSERT_SVH
// Implication checked on every edge outside reset.
`define BCH_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication.
`define BCH_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ----- sv/bch_pkg.sv -----
// ----------------------------------------------------------------------------
// bch_pkg
// Types, constants and helpers of the bar coincidence hit map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bch_pkg;
  localparam int COUNT_BITS  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int NCH   = 12;
  localparam int NBARS = 20;
  localparam int NMAP  = NBARS * NBARS;
  localparam int NPROJ = 2 * NBARS;
  localparam int NBINS = NMAP + NPROJ;
  localparam int ADDR_BITS = 9;
  localparam int BAR_BITS  = 5;
  localparam int CH_BITS   = 4;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_EVENT  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] REG_NOISE  = 2'd0;
  localparam logic [1:0] REG_MINSW  = 2'd1;
  localparam logic [1:0] REG_WSTART = 2'd2;
  localparam logic [1:0] REG_WEND   = 2'd3;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         channel;
    logic [9:0]         sample_index;
    logic signed [15:0] amplitude;
    logic [15:0]        mask_board_a;
    logic [11:0]        mask_board_b;
    logic [15:0]        mask_board_c;
    logic [15:0]        mask_board_d;
    logic [15:0]        mask_board_e;
    logic [3:0]         mask_board_f;
    logic [8:0]         bin_address;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [19:0] x_bars;
    logic [19:0] y_bars;
    logic [31:0] bin_count;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [15:0] noise_limit;
    logic [15:0] min_swing;
    logic [9:0]  window_start;
    logic [10:0] window_end;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_CHAN, ST_BIN_RD, ST_BIN_WR, ST_READ, ST_OUT
  } state_t;

  // Channel check command to the waveform store
  typedef struct packed {
    logic                     read_en;
    logic [CH_BITS-1:0]       read_ch;
    logic                     clear;
  } chan_ctl_t;

  function automatic logic [7:0] pairs8(input logic [15:0] m);
    logic [7:0] r;
    r = '0;
    for (int p = 0; p < 8; p++) r[p] = m[2*p] & m[2*p+1];
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- sv/bch_chan_store.sv -----
// ----------------------------------------------------------------------------
// bch_chan_store
// Per-channel running min/max memory with sample update and event readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bch_chan_store
  import bch_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          smp_valid,
  input  wire logic [CH_BITS-1:0]            smp_ch,
  input  wire logic signed [SAMPLE_BITS-1:0] smp_amp,
  input  wire chan_ctl_t                     ctl,
  output logic signed [SAMPLE_BITS-1:0]      rd_min,
  output logic signed [SAMPLE_BITS-1:0]      rd_max,
  output logic                               rd_seen,
  output logic                               busy
);
  logic signed [SAMPLE_BITS-1:0] mem_min [NCH];
  logic signed [SAMPLE_BITS-1:0] mem_max [NCH];
  logic [NCH-1:0] seen;
  // pending update stage: read done last cycle, write now
  logic                          upd;
  logic [CH_BITS-1:0]            upd_ch;
  logic signed [SAMPLE_BITS-1:0] upd_amp;
  logic signed [SAMPLE_BITS-1:0] q_min, q_max;
  logic                          q_seen;
  logic                          seen_rd;
  logic signed [SAMPLE_BITS-1:0] new_min, new_max;
  logic [CH_BITS-1:0]            rd_ch;

  assign rd_ch = smp_valid ? smp_ch : ctl.read_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      upd <= 1'b0;
    end else begin
      upd <= smp_valid;
    end
    upd_ch  <= smp_ch;
    upd_amp <= smp_amp;
    if (smp_valid || ctl.read_en) begin
      q_min   <= mem_min[rd_ch];
      q_max   <= mem_max[rd_ch];
      seen_rd <= seen[rd_ch];
    end
  end

  always_comb begin
    q_seen  = seen[upd_ch];
    new_min = (!q_seen || upd_amp < q_min) ? upd_amp : q_min;
    new_max = (!q_seen || upd_amp > q_max) ? upd_amp : q_max;
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      mem_min[upd_ch] <= new_min;
      mem_max[upd_ch] <= new_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      seen <= '0;
    end else if (upd) begin
      seen[upd_ch] <= 1'b1;
    end
  end

  // one sample at a time, so no read can hit a pending write
  assign busy    = upd;
  assign rd_min  = q_min;
  assign rd_max  = q_max;
  assign rd_seen = seen_rd;
endmodule
`default_nettype wire

// ----- sv/bch_bin_store.sv -----
// ----------------------------------------------------------------------------
// bch_bin_store
// Histogram bin memory: one read and one write port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bch_bin_store
  import bch_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_BITS-1:0]  rd_addr,
  output logic [COUNT_BITS-1:0]      rd_data,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_BITS-1:0]  wr_addr,
  input  wire logic [COUNT_BITS-1:0] wr_data
);
  logic [COUNT_BITS-1:0] mem [NBINS];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- sv/bar_coincidence_hitmap_unit.sv -----
// ----------------------------------------------------------------------------
// bar_coincidence_hitmap_unit
// Bar hit map: waveform swing check, bar coincidence and 20x20 histogram.
// ----------------------------------------------------------------------------
// In a sample beat the accept cycle reads the channel min/max memory and
// the next writes it back while the input is held off. An event beat has
// the accept cycle, a channel pass that walks the 12 channels through the
// swing check (read, check, then latch the bar masks), a walk over all 440
// bins, one bin per cycle but held by a write-back for each hit bin, and the
// load of the summary beat. A read beat has the accept with the bin memory
// read, the data cycle, and the load of the result beat. A result still
// waiting at the output holds the block in that last load cycle. After
// reset a clearing pass over all 440 bins zeroes the bin memory; no item
// is taken meanwhile, configuration writes always are.
`timescale 1ns / 1ps
`default_nettype none
module bar_coincidence_hitmap_unit
  import bch_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire cfg_item_t cfg_data
);
`include "bar_coincidence_hitmap_unit_assert.svh"
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  cfg_regs_t regs;
  state_t state, state_next;
  logic [ADDR_BITS-1:0] ptr;        // clear pointer / bin walk pointer
  logic [CH_BITS-1:0]   ch_ptr;
  logic [11:0]          mb;         // checked board mask, pruned
  in_item_t             item;
  logic [NBARS-1:0]     xb, yb;
  logic                 out_full;
  out_item_t            out_reg;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{16'd9500, 16'd100, 10'd100, 11'd900};
    end else if (cfg_valid) begin
      case (cfg_data.index)
        REG_NOISE:  regs.noise_limit  <= cfg_data.data;
        REG_MINSW:  regs.min_swing    <= cfg_data.data;
        REG_WSTART: regs.window_start <= cfg_data.data[9:0];
        REG_WEND:   regs.window_end   <= cfg_data.data[10:0];
        default: ;
      endcase
    end
  end

  // Channel store
  logic smp_fire, chan_busy;
  logic signed [SAMPLE_BITS-1:0] rd_min, rd_max;
  logic rd_seen;
  chan_ctl_t ctl;
  logic in_win;
  assign in_win = ({1'b0, in_data.sample_index} >= {1'b0, regs.window_start}) &&
                  ({1'b0, in_data.sample_index} < regs.window_end) &&
                  (in_data.channel < CH_BITS'(NCH));
  assign in_ready = (state == ST_IDLE) && !chan_busy;
  assign smp_fire = in_valid && in_ready && in_data.operation == OP_SAMPLE && in_win;

  always_comb begin
    ctl.read_en = (state == ST_CHAN) && (ch_ptr < CH_BITS'(NCH));
    ctl.read_ch = ch_ptr;
    ctl.clear   = (state == ST_CHAN) && (ch_ptr == CH_BITS'(NCH));
  end

  bch_chan_store u_chan (
    .clk, .rst, .smp_valid(smp_fire), .smp_ch(in_data.channel),
    .smp_amp(in_data.amplitude), .ctl, .rd_min, .rd_max,
    .rd_seen(rd_seen), .busy(chan_busy));

  // Bin store
  logic                  b_rd_en, b_wr_en;
  logic [ADDR_BITS-1:0]  b_rd_addr, b_wr_addr;
  logic [COUNT_BITS-1:0] b_rd_data, b_wr_data;
  bch_bin_store u_bins (
    .clk, .rd_en(b_rd_en), .rd_addr(b_rd_addr), .rd_data(b_rd_data),
    .wr_en(b_wr_en), .wr_addr(b_wr_addr), .wr_data(b_wr_data));

  // Bin walk: address ptr; is it a hit bin?
  logic [BAR_BITS-1:0] bx, by;
  logic                hit_bin, walk_last;
  always_comb begin
    bx = '0; by = '0;
    for (int i = 0; i < NBARS; i++) begin
      if (ptr >= ADDR_BITS'(i*NBARS) && ptr < ADDR_BITS'((i+1)*NBARS)) begin
        bx = BAR_BITS'(i);
        by = BAR_BITS'(ptr - ADDR_BITS'(i*NBARS));
      end
    end
    if (ptr < ADDR_BITS'(NMAP)) hit_bin = xb[bx] & yb[by];
    else if (ptr < ADDR_BITS'(NMAP + NBARS)) hit_bin = xb[BAR_BITS'(ptr - ADDR_BITS'(NMAP))];
    else hit_bin = yb[BAR_BITS'(ptr - ADDR_BITS'(NMAP + NBARS))];
    walk_last = (ptr == ADDR_BITS'(NBINS - 1));
  end

  // Channel swing check, one channel a cycle (read data arrives next cycle);
  // the last check lands in the cycle after the final read, so latch the bar
  // masks in the cycle after that
  logic [CH_BITS-1:0] chk_ch;
  logic               chk_v;
  logic signed [SAMPLE_BITS:0] swing;
  assign swing = {rd_max[SAMPLE_BITS-1], rd_max} - {rd_min[SAMPLE_BITS-1], rd_min};

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (walk_last) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid && in_ready) begin
                   if (in_data.operation == OP_EVENT) state_next = ST_CHAN;
                   else if (in_data.operation == OP_READ) state_next = ST_READ;
                 end
      ST_CHAN:   if (ch_ptr == CH_BITS'(NCH + 1)) state_next = ST_BIN_RD;
      ST_BIN_RD: if (hit_bin) state_next = ST_BIN_WR;
                 else if (walk_last) state_next = ST_OUT;
      ST_BIN_WR: state_next = walk_last ? ST_OUT : ST_BIN_RD;
      ST_READ:   state_next = ST_OUT;
      ST_OUT:    if (!out_full) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    b_rd_en   = (state == ST_BIN_RD) || (state == ST_IDLE);
    b_rd_addr = (state == ST_IDLE) ? in_data.bin_address : ptr;
    b_wr_en   = (state == ST_CLEAR) || (state == ST_BIN_WR);
    b_wr_addr = ptr;
    b_wr_data = (state == ST_CLEAR) ? '0 :
                (b_rd_data == CMAX) ? b_rd_data : b_rd_data + 1'b1;
  end

  logic [NBARS-1:0] x_c, y_c;
  logic [7:0] pa, pc, pd, pe;
  logic [5:0] pb;
  always_comb begin
    pa = pairs8(item.mask_board_a);
    pc = pairs8(item.mask_board_c);
    pd = pairs8(item.mask_board_d);
    pe = pairs8(item.mask_board_e);
    for (int p = 0; p < 6; p++) pb[p] = mb[2*p] & mb[2*p+1];
    x_c = {pd[0], pc, pb[2:0], pa};
    y_c = {item.mask_board_f[3] & item.mask_board_f[2],
           item.mask_board_f[1] & item.mask_board_f[0],
           pe[7:1], pb[5:3], pe[0], pd[7:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ptr <= '0;
      ch_ptr <= '0;
      chk_v <= 1'b0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      chk_v <= (state == ST_CHAN) && (ch_ptr < CH_BITS'(NCH));
      if (out_full && out_ready) out_full <= 1'b0;
      case (state)
        ST_CLEAR:  ptr <= walk_last ? '0 : ptr + 1'b1;
        ST_IDLE:   begin ptr <= '0; ch_ptr <= '0; end
        ST_CHAN:   begin
                     if (ch_ptr != CH_BITS'(NCH + 1)) ch_ptr <= ch_ptr + 1'b1;
                     else begin xb <= x_c; yb <= y_c; end
                   end
        ST_BIN_RD: if (!hit_bin) ptr <= walk_last ? '0 : ptr + 1'b1;
        ST_BIN_WR: ptr <= walk_last ? '0 : ptr + 1'b1;
        ST_OUT:    if (!out_full) out_full <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    chk_ch <= ch_ptr;
    if (state == ST_IDLE && in_valid && in_ready) begin
      item <= in_data;
      mb   <= in_data.mask_board_b;
    end
    if (chk_v) begin
      if (!rd_seen || swing > $signed({1'b0, regs.noise_limit}) ||
          swing < $signed({1'b0, regs.min_swing}))
        mb[chk_ch] <= 1'b0;
    end
    // Load the result beat only once the previous one has left
    if (state == ST_OUT && !out_full) begin
      if (item.operation == OP_READ) begin
        out_reg.result_kind <= KIND_READ;
        out_reg.x_bars <= '0;
        out_reg.y_bars <= '0;
        out_reg.bin_count <= (item.bin_address < ADDR_BITS'(NBINS)) ? b_rd_data : '0;
      end else begin
        out_reg.result_kind <= KIND_EVENT;
        out_reg.x_bars <= xb;
        out_reg.y_bars <= yb;
        out_reg.bin_count <= '0;
      end
    end
  end

  assign out_valid = out_full;
  assign out_data  = out_reg;

  `BCH_ASSERT_IMP(a_no_in_busy, clk, rst, state != ST_IDLE, !in_ready,
                  "item accepted while busy")
  `BCH_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid,
                   "result dropped")
  `BCH_ASSERT_IMP(a_bin_write_state, clk, rst, b_wr_en,
                  state == ST_CLEAR || state == ST_BIN_WR, "stray bin write")
endmodule
`default_nettype wire

// ----- test/bar_coincidence_hitmap_unit_tb.sv -----
// ----------------------------------------------------------------------------
// bar_coincidence_hitmap_unit_tb
// Self-checking bench for the bar hit map: a directed table, then random
// samples, events and bin reads under varying idle patterns, all checked
// against an in-bench model of the swing check, bar coincidence and bins.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module bar_coincidence_hitmap_unit_tb;
  import bch_pkg::*;

  localparam int IN_W = $bits(in_item_t);

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_item_t cfg_data = '0;

  bar_coincidence_hitmap_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: configuration registers, per-channel min/max and the histogram
  logic [15:0]        mdl_noise, mdl_minsw;
  logic [9:0]         mdl_wstart;
  logic [10:0]        mdl_wend;
  logic signed [15:0] ch_lo [NCH];
  logic signed [15:0] ch_hi [NCH];
  logic               ch_seen [NCH];
  logic [31:0]        map_count [NMAP];
  logic [31:0]        proj_count [NPROJ];

  out_item_t pending_results [$];
  int        errors = 0;
  int        n_events = 0, n_reads = 0, n_samples = 0;
  longint    cycle = 0;
  int        send_idle_pct = 0, recv_idle_pct = 0;
  bit        recv_hold = 1'b0;

  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d", cycle);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [9:0] bar_pairs(input logic [15:0] m);
    logic [9:0] r;
    r = '0;
    for (int p = 0; p < 8; p++) r[p] = m[2*p] & m[2*p+1];
    return r;
  endfunction

  function automatic void clear_waveform();
    for (int c = 0; c < NCH; c++) begin
      ch_lo[c] = '0; ch_hi[c] = '0; ch_seen[c] = 1'b0;
    end
  endfunction

  function automatic void bump(ref logic [31:0] c);
    if (c != 32'hFFFF_FFFF) c = c + 1;
  endfunction

  // Advance the model by one accepted beat; queue any result it yields
  function automatic void hitmap_predict(input in_item_t it);
    out_item_t  r;
    logic [11:0] mb;
    logic [9:0]  p;
    logic [19:0] xb, yb;
    int          swing;
    r = '0;
    case (it.operation)
      OP_SAMPLE: begin
        if (it.channel < NCH && it.sample_index >= mdl_wstart &&
            {1'b0, it.sample_index} < mdl_wend) begin
          if (!ch_seen[it.channel]) begin
            ch_seen[it.channel] = 1'b1;
            ch_lo[it.channel] = it.amplitude;
            ch_hi[it.channel] = it.amplitude;
          end else begin
            if (it.amplitude < ch_lo[it.channel]) ch_lo[it.channel] = it.amplitude;
            if (it.amplitude > ch_hi[it.channel]) ch_hi[it.channel] = it.amplitude;
          end
        end
      end
      OP_EVENT: begin
        mb = it.mask_board_b;
        for (int c = 0; c < NCH; c++) begin
          swing = int'(ch_hi[c]) - int'(ch_lo[c]);
          if (!ch_seen[c] || swing > int'(mdl_noise) || swing < int'(mdl_minsw))
            mb[c] = 1'b0;
        end
        xb = '0; yb = '0;
        p = bar_pairs(it.mask_board_a);
        xb[7:0] = p[7:0];
        p = bar_pairs({4'd0, mb});
        xb[10:8] = p[2:0];
        yb[10:8] = p[5:3];
        p = bar_pairs(it.mask_board_c);
        xb[18:11] = p[7:0];
        p = bar_pairs(it.mask_board_d);
        xb[19] = p[0];
        yb[6:0] = p[7:1];
        p = bar_pairs(it.mask_board_e);
        yb[7] = p[0];
        yb[17:11] = p[7:1];
        p = bar_pairs({12'd0, it.mask_board_f});
        yb[19:18] = p[1:0];
        for (int i = 0; i < NBARS; i++) begin
          if (xb[i]) begin
            bump(proj_count[i]);
            for (int j = 0; j < NBARS; j++)
              if (yb[j]) bump(map_count[i*NBARS + j]);
          end
        end
        for (int j = 0; j < NBARS; j++)
          if (yb[j]) bump(proj_count[NBARS + j]);
        clear_waveform();
        r.result_kind = KIND_EVENT;
        r.x_bars = xb;
        r.y_bars = yb;
        pending_results.push_back(r);
      end
      OP_READ: begin
        r.result_kind = KIND_READ;
        if (it.bin_address < NMAP) r.bin_count = map_count[it.bin_address];
        else if (it.bin_address < NBINS) r.bin_count = proj_count[it.bin_address - NMAP];
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        out_item_t e;
        e = pending_results.pop_front();
        if (out_data.result_kind !== e.result_kind) begin
          errors++;
          $display("%0t: result_kind exp %0d got %0d", $time, e.result_kind,
                   out_data.result_kind);
        end
        if (out_data.x_bars !== e.x_bars) begin
          errors++;
          $display("%0t: x_bars exp %h got %h", $time, e.x_bars, out_data.x_bars);
        end
        if (out_data.y_bars !== e.y_bars) begin
          errors++;
          $display("%0t: y_bars exp %h got %h", $time, e.y_bars, out_data.y_bars);
        end
        if (out_data.bin_count !== e.bin_count) begin
          errors++;
          $display("%0t: bin_count exp %0d got %0d", $time, e.bin_count,
                   out_data.bin_count);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Ready is sampled before the edge, the beat counts at the edge itself
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_data  <= '{index: idx, data: val};
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_NOISE:  mdl_noise = val;
      REG_MINSW:  mdl_minsw = val;
      REG_WSTART: mdl_wstart = val[9:0];
      REG_WEND:   mdl_wend = val[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one beat; hold valid and payload until the block takes it.
  // Valid stays up on return; the next offer replaces the beat, an idle drops it.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    hitmap_predict(it);
    case (it.operation)
      OP_EVENT: n_events++;
      OP_READ:  n_reads++;
      default:  n_samples++;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (900) @(posedge clk);
  endtask

  function automatic in_item_t mk_sample(input int ch, input int idx, input int amp);
    in_item_t it;
    it = '0;
    it.operation = OP_SAMPLE;
    it.channel = ch[3:0];
    it.sample_index = idx[9:0];
    it.amplitude = amp[15:0];
    return it;
  endfunction

  function automatic in_item_t mk_event(input logic [15:0] a, input logic [11:0] b,
                                        input logic [15:0] c, input logic [15:0] d,
                                        input logic [15:0] e, input logic [3:0] f);
    in_item_t it;
    it = '0;
    it.operation = OP_EVENT;
    it.mask_board_a = a; it.mask_board_b = b; it.mask_board_c = c;
    it.mask_board_d = d; it.mask_board_e = e; it.mask_board_f = f;
    return it;
  endfunction

  function automatic in_item_t mk_read(input int addr);
    in_item_t it;
    it = '0;
    it.operation = OP_READ;
    it.bin_address = addr[8:0];
    return it;
  endfunction

  // Random beat: mostly well-formed waveforms for a later event
  function automatic in_item_t rand_item();
    in_item_t it;
    int k;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
    k = $urandom_range(99);
    if (k < 70) begin
      it.operation = OP_SAMPLE;
      if ($urandom_range(9) != 0) it.channel = 4'($urandom_range(NCH - 1));
      if ($urandom_range(3) != 0)
        it.amplitude = 16'($signed($urandom_range(1200)) - 600);
    end else if (k < 80) begin
      it.operation = OP_EVENT;
      if ($urandom_range(1)) begin
        it.mask_board_a &= 16'($urandom); it.mask_board_c &= 16'($urandom);
        it.mask_board_d &= 16'($urandom); it.mask_board_e &= 16'($urandom);
      end
    end else if (k < 97) begin
      it.operation = OP_READ;
      if ($urandom_range(9) != 0) it.bin_address = 9'($urandom_range(NBINS - 1));
    end else begin
      it.operation = 2'd3;
    end
    return it;
  endfunction

  // Directed table; expected bin_count typed only where obvious
  typedef struct {
    in_item_t   it;
    bit         has_exp;
    logic [31:0] exp_count;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    in_item_t it;
    for (int c = 0; c < NCH; c++) begin
      ch_lo[c] = '0; ch_hi[c] = '0; ch_seen[c] = 1'b0;
    end
    foreach (map_count[k]) map_count[k] = '0;
    foreach (proj_count[k]) proj_count[k] = '0;
    mdl_noise = 16'd9500; mdl_minsw = 16'd100; mdl_wstart = 10'd100; mdl_wend = 11'd900;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Bins start at zero, out-of-range address reads zero
    dir_rows.push_back('{mk_read(0), 1, 32'd0});
    dir_rows.push_back('{mk_read(439), 1, 32'd0});
    dir_rows.push_back('{mk_read(511), 1, 32'd0});
    // Window edges and amplitude extremes
    dir_rows.push_back('{mk_sample(0, 99, 500), 0, 0});
    dir_rows.push_back('{mk_sample(0, 100, -32768), 0, 0});
    dir_rows.push_back('{mk_sample(0, 899, 32767), 0, 0});
    dir_rows.push_back('{mk_sample(0, 900, 0), 0, 0});
    dir_rows.push_back('{mk_sample(1, 500, 0), 0, 0});
    dir_rows.push_back('{mk_sample(1, 501, 150), 0, 0});
    dir_rows.push_back('{mk_sample(15, 500, 9), 0, 0});
    dir_rows.push_back('{mk_sample(2, 500, 10), 0, 0});
    dir_rows.push_back('{mk_sample(2, 501, 50), 0, 0});
    it = '1; it.operation = 2'd3;
    dir_rows.push_back('{it, 0, 0});
    // All masks full: noise, good, too-small swing and unseen channels
    dir_rows.push_back('{mk_event('1, '1, '1, '1, '1, '1), 0, 0});
    dir_rows.push_back('{mk_read(0), 1, 32'd1});
    dir_rows.push_back('{mk_read(NMAP + 39), 1, 32'd1});
    dir_rows.push_back('{mk_event('0, '0, '0, '0, '0, '0), 0, 0});
    dir_rows.push_back('{mk_event(16'h0003, 12'hFFF, 16'h8000, 16'h000C, 16'h0001, 4'hC),
                        0, 0});
    dir_rows.push_back('{mk_read(NMAP), 1, 32'd2});
    dir_rows.push_back('{mk_read(NMAP + 19), 1, 32'd1});
    foreach (dir_rows[r]) begin
      send_item(dir_rows[r].it);
      if (dir_rows[r].has_exp && pending_results[$].bin_count !== dir_rows[r].exp_count) begin
        errors++;
        $display("%0t: table row %0d exp %0d model %0d", $time, r,
                 dir_rows[r].exp_count, pending_results[$].bin_count);
      end
    end
    drain();

    // Random phases under several register settings, extremes among them
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_NOISE, 16'd800); write_reg(REG_MINSW, 16'd50);
                 write_reg(REG_WSTART, 16'd0); write_reg(REG_WEND, 16'd1024); end
        1: begin write_reg(REG_NOISE, 16'hFFFF); write_reg(REG_MINSW, 16'd0); end
        2: begin write_reg(REG_NOISE, 16'd0); write_reg(REG_MINSW, 16'hFFFF);
                 write_reg(REG_WSTART, 16'd1023); write_reg(REG_WEND, 16'd0); end
        3: begin write_reg(REG_NOISE, 16'd600); write_reg(REG_MINSW, 16'd20);
                 write_reg(REG_WSTART, 16'd200); write_reg(REG_WEND, 16'd700); end
        default: begin write_reg(REG_NOISE, 16'd9500); write_reg(REG_MINSW, 16'd100);
                 write_reg(REG_WSTART, 16'd100); write_reg(REG_WEND, 16'd900); end
      endcase
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 55 : 0;
      recv_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 36 : 0;
      for (int n = 0; n < 190; n++) begin
        // Hold the receiver off while the sender keeps offering beats
        if (ph == 3 && n == 40) begin
          recv_hold = 1'b1;
          fork
            begin repeat (3000) @(posedge clk); recv_hold = 1'b0; end
          join_none
        end
        // Pause the sender until everything expected has come back
        if (ph == 4 && n == 95 && pending_results.size() != 0) begin
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        send_item(rand_item());
      end
      drain();
    end

    $display("Covered %0d samples, %0d events and %0d bin reads over 6 register settings",
             n_samples, n_events, n_reads);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule
